// File: src/ckbw_pkg.sv
package ckbw_pkg;

  // Field and register widths
  localparam int SIDE_W     = 13;
  localparam int KEY_W      = 24;
  localparam int PIXEL_W    = 32;
  localparam int INDEX_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Depth of the queue between the classifier and the address stage
  localparam int QUEUE_DEPTH = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COPY_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COPY_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE  = 3'd7;

  // Reset values of the registers
  localparam logic [SIDE_W-1:0] RST_DEST_WIDTH  = 13'd640;
  localparam logic [SIDE_W-1:0] RST_DEST_HEIGHT = 13'd480;
  localparam logic [SIDE_W-1:0] RST_COPY_SIDE   = 13'd1;

  // One classified pixel waiting for its address
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               in_dest;
    logic               write_en;
    logic               last;
    logic [SIDE_W-1:0]  dx;
    logic [SIDE_W-1:0]  dy;
  } queue_entry_t;

endpackage

// File: src/ckbw_in_if.sv
interface ckbw_in_if;
  logic                         valid;
  logic                         ready;
  logic [ckbw_pkg::PIXEL_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

// File: src/ckbw_out_if.sv
interface ckbw_out_if;
  logic                         valid;
  logic                         ready;
  logic [ckbw_pkg::INDEX_W-1:0] dest_index;
  logic [ckbw_pkg::PIXEL_W-1:0] pixel_out;
  logic                         write_enable;
  logic                         last_pixel;

  modport source (output valid, output dest_index, output pixel_out,
                  output write_enable, output last_pixel, input ready);
  modport sink (input valid, input dest_index, input pixel_out,
                input write_enable, input last_pixel, output ready);
endinterface

// File: src/color_key_blit_writer.sv
// Channel     Dir  Payload                                            Handshake
// pixels_in   in   src_pixel[31:0]                                    valid/ready
// writes_out  out  dest_index[23:0] pixel_out[31:0] write_enable      valid/ready
//                  last_pixel
// cfg         in   cfg_index[2:0] cfg_data[23:0]                      cfg_write
//
// One word per clock sustained while writes_out is ready; an accepted word is
// written into the queue, and its multiply-add result is then loaded into the
// output register that drives writes_out.
// A four-entry queue between the classifier and the address stage absorbs stalls,
// so pixels_in stays ready until the queue fills.
// Synchronous reset clears the window position, the queue and the output valid,
// and restores the register defaults.
module color_key_blit_writer #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ckbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckbw_pkg::CFG_DATA_W-1:0] cfg_data,
  ckbw_in_if.sink                         pixels_in,
  ckbw_out_if.source                      writes_out
);

  ckbw_pkg::queue_entry_t      push_entry;
  ckbw_pkg::queue_entry_t      pop_entry;
  logic                        push;
  logic                        q_full;
  logic                        pop;
  logic                        pop_valid;
  logic [ckbw_pkg::SIDE_W-1:0] dest_pitch;

  // Accept and classify
  ckbw_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixels_in  (pixels_in),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry),
    .dest_pitch (dest_pitch)
  );

  // Decouple front from back
  ckbw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // Compute address and drive the result
  ckbw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_entry    (pop_entry),
    .pop        (pop),
    .dest_pitch (dest_pitch),
    .writes_out (writes_out)
  );

endmodule

// File: src/ckbw_front.sv
module ckbw_front #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ckbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckbw_pkg::CFG_DATA_W-1:0] cfg_data,
  ckbw_in_if.sink                         pixels_in,
  input  logic                            q_full,
  output logic                            push,
  output ckbw_pkg::queue_entry_t          entry,
  output logic [ckbw_pkg::SIDE_W-1:0]     dest_pitch
);

  localparam int SW      = ckbw_pkg::SIDE_W;
  localparam int CNT_W   = $clog2(MAX_SIDE);
  localparam int WIDE_W  = ((CNT_W > SW) ? CNT_W : SW) + 2;
  localparam int SIDE_MAX = (1 << SW) - 1;
  localparam logic [SW-1:0] SIDE_LIM = SW'((MAX_SIDE > SIDE_MAX) ? SIDE_MAX : MAX_SIDE);

  logic [SW-1:0]               dest_width;
  logic [SW-1:0]               dest_height;
  logic [SW-1:0]               origin_x;
  logic [SW-1:0]               origin_y;
  logic [SW-1:0]               copy_width;
  logic [SW-1:0]               copy_height;
  logic [ckbw_pkg::KEY_W-1:0]  key_color;
  logic                        key_enable;

  logic [CNT_W-1:0]            column_count;
  logic [CNT_W-1:0]            row_count;
  logic [CNT_W-1:0]            column_count_next;
  logic [CNT_W-1:0]            row_count_next;

  logic [SW-1:0]               dw;
  logic [SW-1:0]               dh;
  logic [SW-1:0]               cw;
  logic [SW-1:0]               ch;
  logic signed [WIDE_W-1:0]    dx;
  logic signed [WIDE_W-1:0]    dy;
  logic [WIDE_W-1:0]           row_plus;
  logic [WIDE_W-1:0]           col_plus;
  logic                        in_dest;
  logic                        transparent;
  logic                        row_end;
  logic                        col_end;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width  <= ckbw_pkg::RST_DEST_WIDTH;
      dest_height <= ckbw_pkg::RST_DEST_HEIGHT;
      origin_x    <= '0;
      origin_y    <= '0;
      copy_width  <= ckbw_pkg::RST_COPY_SIDE;
      copy_height <= ckbw_pkg::RST_COPY_SIDE;
      key_color   <= '0;
      key_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ckbw_pkg::REG_DEST_WIDTH:  dest_width  <= cfg_data[SW-1:0];
        ckbw_pkg::REG_DEST_HEIGHT: dest_height <= cfg_data[SW-1:0];
        ckbw_pkg::REG_ORIGIN_X:    origin_x    <= cfg_data[SW-1:0];
        ckbw_pkg::REG_ORIGIN_Y:    origin_y    <= cfg_data[SW-1:0];
        ckbw_pkg::REG_COPY_WIDTH:  copy_width  <= cfg_data[SW-1:0];
        ckbw_pkg::REG_COPY_HEIGHT: copy_height <= cfg_data[SW-1:0];
        ckbw_pkg::REG_KEY_COLOR:   key_color   <= cfg_data[ckbw_pkg::KEY_W-1:0];
        ckbw_pkg::REG_KEY_ENABLE:  key_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate sides; a zero copy side acts as one, a zero destination side stays empty
  always_comb begin
    dw = (dest_width > SIDE_LIM) ? SIDE_LIM : dest_width;
    dh = (dest_height > SIDE_LIM) ? SIDE_LIM : dest_height;
    cw = (copy_width > SIDE_LIM) ? SIDE_LIM :
         ((copy_width == '0) ? SW'(1) : copy_width);
    ch = (copy_height > SIDE_LIM) ? SIDE_LIM :
         ((copy_height == '0) ? SW'(1) : copy_height);
  end

  // Place the pixel and classify it
  always_comb begin
    dx = WIDE_W'($signed(origin_x)) + $signed(WIDE_W'(column_count));
    dy = WIDE_W'($signed(origin_y)) + $signed(WIDE_W'(row_count));
    in_dest = (dx >= 0) && (dy >= 0) &&
              (dx < $signed(WIDE_W'(dw))) && (dy < $signed(WIDE_W'(dh)));
    transparent = key_enable && (pixels_in.src_pixel[ckbw_pkg::KEY_W-1:0] == key_color);
    row_plus = WIDE_W'(row_count) + WIDE_W'(1);
    col_plus = WIDE_W'(column_count) + WIDE_W'(1);
    row_end = row_plus >= WIDE_W'(ch);
    col_end = col_plus >= WIDE_W'(cw);
  end

  // Advance the window position, column-major
  always_comb begin
    row_count_next    = row_count;
    column_count_next = column_count;
    if (row_end) begin
      row_count_next    = '0;
      column_count_next = col_end ? '0 : col_plus[CNT_W-1:0];
    end else begin
      row_count_next = row_plus[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Hand the classified word to the queue
  assign pixels_in.ready = !q_full;
  assign push            = pixels_in.valid && !q_full;
  assign dest_pitch      = dw;

  always_comb begin
    entry.pixel    = pixels_in.src_pixel;
    entry.in_dest  = in_dest;
    entry.write_en = in_dest && !transparent;
    entry.last     = row_end && col_end;
    entry.dx       = dx[SW-1:0];
    entry.dy       = dy[SW-1:0];
  end

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    push && entry.last |=> (column_count == '0) && (row_count == '0))
    else $error("window position did not wrap after the last word");

  a_write_in_dest: assert property (@(posedge clk) disable iff (rst)
    push && entry.write_en |-> entry.in_dest &&
      (entry.dx < dw) && (entry.dy < dh))
    else $error("write strobe outside the destination");

endmodule

// File: src/ckbw_queue.sv
module ckbw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ckbw_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   pop_valid,
  output ckbw_pkg::queue_entry_t pop_entry
);

  localparam int DEPTH = ckbw_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ckbw_pkg::queue_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_entry = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == CNT_W'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with occupancy");

endmodule

// File: src/ckbw_back.sv
module ckbw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ckbw_pkg::queue_entry_t      q_entry,
  output logic                        pop,
  input  logic [ckbw_pkg::SIDE_W-1:0] dest_pitch,
  ckbw_out_if.source                  writes_out
);

  localparam int SW    = ckbw_pkg::SIDE_W;
  localparam int SUM_W = 2 * SW + 1;

  logic [2*SW-1:0]  product;
  logic [SUM_W-1:0] sum;
  logic             take;
  logic             out_valid;

  // Linear address: row times pitch plus column
  always_comb begin
    product = q_entry.dy * dest_pitch;
    sum     = SUM_W'(product) + SUM_W'(q_entry.dx);
  end

  // Load the output register when it is empty or being drained
  assign take = !out_valid || writes_out.ready;
  assign pop  = q_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      writes_out.dest_index   <= q_entry.in_dest ? sum[ckbw_pkg::INDEX_W-1:0] : '0;
      writes_out.pixel_out    <= q_entry.pixel;
      writes_out.write_enable <= q_entry.write_en;
      writes_out.last_pixel   <= q_entry.last;
    end
  end

  assign writes_out.valid = out_valid;

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    pop && !q_entry.in_dest |=> (writes_out.dest_index == '0) && !writes_out.write_enable)
    else $error("word outside the destination carries an address");

endmodule
